// ===== src/lru_pr_pkg.sv =====
// shared constants, types and state codes for the lru page replacement block
// no dependencies; compile first
package lru_pr_pkg;

   // sizing
   localparam int FRAMES  = 8;
   localparam int PAGES   = 64;
   localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

   // fixed field widths on the channels
   localparam int PAGE_ID_W   = 6;
   localparam int FRAME_OUT_W = 3;
   localparam int CNT_W       = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // item kinds
   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN_RD,
      ST_SCAN_END,
      ST_LOAD,
      ST_FINISH
   } state_type;

   // one frame table word
   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [CNT_W-1:0]  stamp;
   } frame_entry_type;

   // frame table access
   typedef struct packed {
      logic               rd_en;
      logic [FRAME_W-1:0] rd_addr;
      logic               wr_en;
      logic [FRAME_W-1:0] wr_addr;
      frame_entry_type    wr_data;
   } frame_req_type;

   // page table access
   typedef struct packed {
      logic               rd_en;
      logic [PAGE_W-1:0]  rd_addr;
      logic               set_en;
      logic [PAGE_W-1:0]  set_addr;
      logic [FRAME_W-1:0] set_frame;
      logic               drop_en;
      logic [PAGE_W-1:0]  drop_addr;
      logic               clear;
   } page_req_type;

   // page table read data
   typedef struct packed {
      logic               resident;
      logic [FRAME_W-1:0] frame;
   } page_rsp_type;

endpackage

// ===== src/lru_pr_if.sv =====
// valid/ready channel interfaces for access items and result items
// depends on lru_pr_pkg
interface lru_pr_req_if import lru_pr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [PAGE_ID_W-1:0] page_id;

   modport source (output valid, output kind, output page_id, input ready);
   modport sink   (input valid, input kind, input page_id, output ready);
endinterface

interface lru_pr_rsp_if import lru_pr_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [FRAME_OUT_W-1:0] frame;
   logic                   evicted_valid;
   logic [PAGE_ID_W-1:0]   evicted_page;
   logic [CNT_W-1:0]       fault_count;
   logic                   time_saturated;

   modport source (output valid, output hit, output frame, output evicted_valid,
                   output evicted_page, output fault_count, output time_saturated,
                   input ready);
   modport sink   (input valid, input hit, input frame, input evicted_valid,
                   input evicted_page, input fault_count, input time_saturated,
                   output ready);
endinterface

// ===== src/lru_pr_frame_tbl.sv =====
// frame table memory: resident page and lru stamp per frame
// one read and one write port, registered read data; depends on lru_pr_pkg
module lru_pr_frame_tbl import lru_pr_pkg::*; (
   input  logic            clock,
   input  frame_req_type   req,
   output frame_entry_type rd_data
);

   frame_entry_type frame_mem_ff [FRAMES];
   frame_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         frame_mem_ff[req.wr_addr] <= req.wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= frame_mem_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lru_pr_page_tbl.sv =====
// page table: frame number memory plus per-page resident flags
// resident flags clear at once on reset or clear; depends on lru_pr_pkg
module lru_pr_page_tbl import lru_pr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  page_req_type req,
   output page_rsp_type rsp
);

   logic [FRAME_W-1:0] page_mem_ff [PAGES];
   logic [PAGES-1:0]   resident_ff;
   page_rsp_type       rsp_ff;

   // frame number write
   always_ff @(posedge clock) begin
      if (req.set_en) begin
         page_mem_ff[req.set_addr] <= req.set_frame;
      end
   end

   // resident flags, drop of the evicted page before set of the new one
   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         resident_ff <= '0;
      end else begin
         if (req.drop_en) begin
            resident_ff[req.drop_addr] <= 1'b0;
         end
         if (req.set_en) begin
            resident_ff[req.set_addr] <= 1'b1;
         end
      end
   end

   // registered lookup
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rsp_ff.frame    <= page_mem_ff[req.rd_addr];
         rsp_ff.resident <= resident_ff[req.rd_addr];
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== src/lru_pr_ctrl.sv =====
// sequencer for lookup, lru victim scan and load, counters and result beat register
// drives both table memories; depends on lru_pr_pkg and the channel interfaces
module lru_pr_ctrl import lru_pr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   lru_pr_req_if.sink      req_chan,
   lru_pr_rsp_if.source    rsp_chan,
   output frame_req_type   frame_req,
   input  frame_entry_type frame_rd,
   output page_req_type    page_req,
   input  page_rsp_type    page_rsp
);

   state_type          state_ff, state_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [FRAMES-1:0]  frame_valid_ff, frame_valid_in;
   logic [CNT_W-1:0]   time_ff, time_in;
   logic [CNT_W-1:0]   faults_ff, faults_in;
   logic               hit_ff, hit_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               ev_ff, ev_in;
   logic [PAGE_W-1:0]  ev_page_ff, ev_page_in;
   logic [FRAME_W-1:0] iss_ff, iss_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [FRAME_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [FRAME_W-1:0] best_idx_ff, best_idx_in;
   logic [CNT_W-1:0]   best_stamp_ff, best_stamp_in;
   logic [PAGE_W-1:0]  best_page_ff, best_page_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic                   rsp_ev_ff, rsp_ev_in;
   logic [PAGE_ID_W-1:0]   rsp_ev_page_ff, rsp_ev_page_in;
   logic [CNT_W-1:0]       rsp_faults_ff, rsp_faults_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   logic               req_fire;
   logic               in_range;
   logic [PAGE_W-1:0]  page_idx;
   logic               hit_now;
   logic               full;
   logic [FRAME_W-1:0] free_idx;
   logic [FRAME_W-1:0] load_idx;
   logic               iss_last;
   logic               out_free;
   logic               push;
   logic [CNT_W-1:0]   time_next;

   // handshake and decode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_range       = 32'(req_chan.page_id) < 32'(PAGES);
   assign page_idx       = PAGE_W'(req_chan.page_id);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign full           = &frame_valid_ff;
   assign iss_last       = (iss_ff == FRAME_W'(FRAMES - 1));
   assign load_idx       = ev_ff ? best_idx_ff : free_idx;
   assign time_next      = (time_ff == CNT_MAX) ? time_ff : time_ff + CNT_W'(1);

   // resident page whose frame is still live
   assign hit_now = page_rsp.resident && (32'(page_rsp.frame) < 32'(FRAMES)) &&
                    frame_valid_ff[page_rsp.frame];

   // lowest free frame
   always_comb begin
      free_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (!frame_valid_ff[i]) begin
            free_idx = FRAME_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_CLEAR || !in_range) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (hit_now) begin
               state_in = ST_FINISH;
            end else if (full) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_SCAN_RD: begin
            if (iss_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = ST_LOAD;
         ST_LOAD:     state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory requests and result push
   always_comb begin
      frame_req = '0;
      page_req  = '0;
      push      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            page_req.rd_en   = req_fire && req_chan.kind == KIND_ACCESS && in_range;
            page_req.rd_addr = page_idx;
            page_req.clear   = req_fire && req_chan.kind == KIND_CLEAR;
         end
         ST_LOOKUP: begin
            frame_req.wr_en         = hit_now;
            frame_req.wr_addr       = page_rsp.frame;
            frame_req.wr_data.page  = page_ff;
            frame_req.wr_data.stamp = time_ff;
         end
         ST_SCAN_RD: begin
            frame_req.rd_en   = 1'b1;
            frame_req.rd_addr = iss_ff;
         end
         ST_LOAD: begin
            frame_req.wr_en         = 1'b1;
            frame_req.wr_addr       = load_idx;
            frame_req.wr_data.page  = page_ff;
            frame_req.wr_data.stamp = time_ff;
            page_req.set_en         = 1'b1;
            page_req.set_addr       = page_ff;
            page_req.set_frame      = load_idx;
            page_req.drop_en        = ev_ff;
            page_req.drop_addr      = best_page_ff;
         end
         ST_FINISH: push = out_free;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      page_in        = page_ff;
      frame_valid_in = frame_valid_ff;
      time_in        = time_ff;
      faults_in      = faults_ff;
      hit_in         = hit_ff;
      frame_in       = frame_ff;
      ev_in          = ev_ff;
      ev_page_in     = ev_page_ff;
      iss_in         = iss_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      best_idx_in    = best_idx_ff;
      best_stamp_in  = best_stamp_ff;
      best_page_in   = best_page_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               page_in    = page_idx;
               hit_in     = 1'b0;
               frame_in   = '0;
               ev_in      = 1'b0;
               ev_page_in = '0;
               if (req_chan.kind == KIND_CLEAR) begin
                  frame_valid_in = '0;
                  time_in        = '0;
                  faults_in      = '0;
               end
            end
         end
         ST_LOOKUP: begin
            if (hit_now) begin
               hit_in   = 1'b1;
               frame_in = page_rsp.frame;
               time_in  = time_next;
            end else begin
               if (faults_ff != CNT_MAX) begin
                  faults_in = faults_ff + CNT_W'(1);
               end
               ev_in  = full;
               iss_in = '0;
            end
         end
         ST_SCAN_RD: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = iss_ff;
            iss_in     = iss_ff + FRAME_W'(1);
         end
         ST_LOAD: begin
            frame_valid_in[load_idx] = 1'b1;
            frame_in   = load_idx;
            ev_page_in = ev_ff ? best_page_ff : '0;
            time_in    = time_next;
         end
         default: ;
      endcase

      // running minimum over returning stamps, strict less keeps lowest index
      if (cmp_vld_ff) begin
         if (cmp_idx_ff == '0 || frame_rd.stamp < best_stamp_ff) begin
            best_idx_in   = cmp_idx_ff;
            best_stamp_in = frame_rd.stamp;
            best_page_in  = frame_rd.page;
         end
      end
   end

   // result beat register
   always_comb begin
      rsp_valid_in   = push || (rsp_valid_ff && !rsp_chan.ready);
      rsp_hit_in     = rsp_hit_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_ev_page_in = rsp_ev_page_ff;
      rsp_faults_in  = rsp_faults_ff;
      rsp_sat_in     = rsp_sat_ff;
      if (push) begin
         rsp_hit_in     = hit_ff;
         rsp_frame_in   = FRAME_OUT_W'(frame_ff);
         rsp_ev_in      = ev_ff;
         rsp_ev_page_in = PAGE_ID_W'(ev_page_ff);
         rsp_faults_in  = faults_ff;
         rsp_sat_in     = (time_ff == CNT_MAX);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_valid_ff <= '0;
         time_ff        <= '0;
         faults_ff      <= '0;
         cmp_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_valid_ff <= frame_valid_in;
         time_ff        <= time_in;
         faults_ff      <= faults_in;
         cmp_vld_ff     <= cmp_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      hit_ff         <= hit_in;
      frame_ff       <= frame_in;
      ev_ff          <= ev_in;
      ev_page_ff     <= ev_page_in;
      iss_ff         <= iss_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_idx_ff    <= best_idx_in;
      best_stamp_ff  <= best_stamp_in;
      best_page_ff   <= best_page_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_ev_page_ff <= rsp_ev_page_in;
      rsp_faults_ff  <= rsp_faults_in;
      rsp_sat_ff     <= rsp_sat_in;
   end

   // result channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.hit            = rsp_hit_ff;
   assign rsp_chan.frame          = rsp_frame_ff;
   assign rsp_chan.evicted_valid  = rsp_ev_ff;
   assign rsp_chan.evicted_page   = rsp_ev_page_ff;
   assign rsp_chan.fault_count    = rsp_faults_ff;
   assign rsp_chan.time_saturated = rsp_sat_ff;

endmodule

// ===== src/lru_page_replacement.sv =====
// lru page replacement, one item at a time; the next beat is taken once the previous result
// is in the output register. a clear or an out-of-range page goes straight to the finish
// state, a hit passes through lookup, a miss with a free frame through lookup and load, and
// a miss with eviction through lookup, the one-frame-per-cycle stamp scan through the frame
// table read port, scan end and load. an item can be taken in the cycle after the previous
// one finishes. synchronous reset empties all frames and zeroes the counters; no clearing pass.
// depends on lru_pr_pkg, the channel interfaces and the ctrl and table modules
module lru_page_replacement import lru_pr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   lru_pr_req_if.sink   req_chan,
   lru_pr_rsp_if.source rsp_chan
);

   frame_req_type   frame_req;
   frame_entry_type frame_rd;
   page_req_type    page_req;
   page_rsp_type    page_rsp;

   // sequencer
   lru_pr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .frame_req (frame_req),
      .frame_rd  (frame_rd),
      .page_req  (page_req),
      .page_rsp  (page_rsp)
   );

   // frame table
   lru_pr_frame_tbl u_frame_tbl (
      .clock   (clock),
      .req     (frame_req),
      .rd_data (frame_rd)
   );

   // page table
   lru_pr_page_tbl u_page_tbl (
      .clock (clock),
      .reset (reset),
      .req   (page_req),
      .rsp   (page_rsp)
   );

endmodule

// ===== src/lru_pr_checker.sv =====
// port-level checks for lru_page_replacement, attached by bind
// depends on lru_pr_pkg and the top level
module lru_pr_checker import lru_pr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_hit,
   input logic [FRAME_OUT_W-1:0] rsp_frame,
   input logic                   rsp_evicted_valid,
   input logic [PAGE_ID_W-1:0]   rsp_evicted_page,
   input logic [CNT_W-1:0]       rsp_fault_count,
   input logic                   rsp_time_saturated
);

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] pend_ff, pend_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // items accepted but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_frame) &&
      $stable(rsp_evicted_valid) && $stable(rsp_evicted_page) &&
      $stable(rsp_fault_count) && $stable(rsp_time_saturated))
      else $error("result beat changed while stalled");

   // no result left over after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // every result belongs to an accepted item
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pend_ff != 2'd0)
      else $error("result without an outstanding item");

   // an eviction only comes with a fault
   a_evict_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_evicted_valid |-> !rsp_hit && rsp_fault_count != '0)
      else $error("eviction reported without a fault");

endmodule

bind lru_page_replacement lru_pr_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_hit            (rsp_chan.hit),
   .rsp_frame          (rsp_chan.frame),
   .rsp_evicted_valid  (rsp_chan.evicted_valid),
   .rsp_evicted_page   (rsp_chan.evicted_page),
   .rsp_fault_count    (rsp_chan.fault_count),
   .rsp_time_saturated (rsp_chan.time_saturated)
);

// ===== sim/lru_page_replacement_tb.sv =====
// self-checking testbench for lru_page_replacement: random valid/ready gaps on both channels,
// results checked beat by beat against an in-bench lru frame table predictor
// depends on lru_pr_pkg, the channel interfaces and the lru_page_replacement rtl
module lru_page_replacement_tb import lru_pr_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  N_RANDOM   = 450;
   localparam int  MAX_PRINTS = 50;
   localparam real TIMEOUT_NS = 5_000_000.0;

   typedef struct packed {
      logic                 kind;
      logic [PAGE_ID_W-1:0] page;
   } page_request_type;

   typedef struct packed {
      logic                   hit;
      logic [FRAME_OUT_W-1:0] frame;
      logic                   evicted_valid;
      logic [PAGE_ID_W-1:0]   evicted_page;
      logic [CNT_W-1:0]       fault_count;
      logic                   time_saturated;
   } lru_result_type;

   logic clock;
   logic reset;

   lru_pr_req_if req_bus ();
   lru_pr_rsp_if rsp_bus ();

   lru_page_replacement i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // stimulus and expected results
   page_request_type pending_accesses[$];
   lru_result_type   awaited_results[$];

   // predictor copy of the frame and page tables
   logic                 slot_busy  [FRAMES];
   logic [PAGE_W-1:0]    slot_page  [FRAMES];
   logic [CNT_W-1:0]     slot_stamp [FRAMES];
   logic                 page_held  [PAGES];
   logic [FRAME_W-1:0]   page_slot  [PAGES];
   logic [CNT_W-1:0]     model_time;
   logic [CNT_W-1:0]     model_faults;
   int                   slots_used;

   int mismatch_count;
   int beats_sent;
   int beats_checked;
   int hit_count;
   int evict_count;
   int clear_count;

   int send_gap;
   bit send_quiet;
   int stall_left;
   bit take_quiet;
   page_request_type next_item;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void empty_tables();
      for (int i = 0; i < FRAMES; i++) begin
         slot_busy[i]  = 1'b0;
         slot_page[i]  = '0;
         slot_stamp[i] = '0;
      end
      for (int p = 0; p < PAGES; p++) begin
         page_held[p] = 1'b0;
         page_slot[p] = '0;
      end
      model_time   = '0;
      model_faults = '0;
      slots_used   = 0;
   endfunction

   // expected result of one access or clear, updating the predictor tables
   function automatic lru_result_type predict_access(logic kind, logic [PAGE_ID_W-1:0] page);
      lru_result_type r;
      int victim;
      int slot;
      logic [CNT_W-1:0] now;
      r = '0;
      if (kind == KIND_CLEAR) begin
         empty_tables();
         clear_count++;
      end else if (int'(page) < PAGES) begin
         now = model_time;
         if (page_held[page] && slot_busy[page_slot[page]]) begin
            r.hit   = 1'b1;
            r.frame = FRAME_OUT_W'(page_slot[page]);
            slot_stamp[page_slot[page]] = now;
            hit_count++;
         end else begin
            if (model_faults != CNT_MAX)
               model_faults++;
            // all frames taken: drop the least recently used, lowest index on a tie
            if (slots_used >= FRAMES) begin
               victim = 0;
               for (int i = 1; i < FRAMES; i++)
                  if (slot_stamp[i] < slot_stamp[victim])
                     victim = i;
               r.evicted_valid = 1'b1;
               r.evicted_page  = PAGE_ID_W'(slot_page[victim]);
               page_held[slot_page[victim]] = 1'b0;
               slot_busy[victim] = 1'b0;
               slots_used = FRAMES - 1;
               evict_count++;
            end
            // lowest free frame
            slot = 0;
            for (int i = FRAMES - 1; i >= 0; i--)
               if (!slot_busy[i])
                  slot = i;
            slot_busy[slot]  = 1'b1;
            slot_page[slot]  = PAGE_W'(page);
            slot_stamp[slot] = now;
            page_held[page]  = 1'b1;
            page_slot[page]  = FRAME_W'(slot);
            slots_used++;
            r.frame = FRAME_OUT_W'(slot);
         end
         if (model_time != CNT_MAX)
            model_time++;
      end
      r.fault_count    = model_faults;
      r.time_saturated = (model_time == CNT_MAX);
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_cycles(bit quiet);
      int roll;
      if (quiet)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic check_result();
      lru_result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result beat with nothing awaited");
         return;
      end
      want = awaited_results.pop_front();
      beats_checked++;
      if (rsp_bus.hit !== want.hit)
         report_mismatch($sformatf("beat %0d hit %b, expected %b",
                                   beats_checked, rsp_bus.hit, want.hit));
      if (rsp_bus.frame !== want.frame)
         report_mismatch($sformatf("beat %0d frame %0d, expected %0d",
                                   beats_checked, rsp_bus.frame, want.frame));
      if (rsp_bus.evicted_valid !== want.evicted_valid)
         report_mismatch($sformatf("beat %0d evicted_valid %b, expected %b",
                                   beats_checked, rsp_bus.evicted_valid, want.evicted_valid));
      if (rsp_bus.evicted_page !== want.evicted_page)
         report_mismatch($sformatf("beat %0d evicted_page %0d, expected %0d",
                                   beats_checked, rsp_bus.evicted_page, want.evicted_page));
      if (rsp_bus.fault_count !== want.fault_count)
         report_mismatch($sformatf("beat %0d fault_count %0d, expected %0d",
                                   beats_checked, rsp_bus.fault_count, want.fault_count));
      if (rsp_bus.time_saturated !== want.time_saturated)
         report_mismatch($sformatf("beat %0d time_saturated %b, expected %b",
                                   beats_checked, rsp_bus.time_saturated,
                                   want.time_saturated));
   endtask

   // request driver: predicts each accepted beat, then issues the next one after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.kind    <= KIND_ACCESS;
         req_bus.page_id <= '0;
         send_gap = 0;
         empty_tables();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_results.push_back(predict_access(req_bus.kind, req_bus.page_id));
            beats_sent++;
            if ($urandom_range(0, 39) == 0)
               send_quiet = !send_quiet;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               next_item = pending_accesses.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.kind    <= next_item.kind;
               req_bus.page_id <= next_item.page;
               send_gap = idle_cycles(send_quiet);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_result();
         if ($urandom_range(0, 59) == 0)
            take_quiet = !take_quiet;
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = idle_cycles(take_quiet);
         end
      end
   end

   function automatic void queue_access(logic [PAGE_ID_W-1:0] page);
      pending_accesses.push_back('{kind: KIND_ACCESS, page: page});
   endfunction

   function automatic void queue_clear(logic [PAGE_ID_W-1:0] page);
      pending_accesses.push_back('{kind: KIND_CLEAR, page: page});
   endfunction

   // wait until every queued beat has gone and every result is back
   task automatic drain();
      while (pending_accesses.size() > 0 || req_bus.valid || awaited_results.size() > 0)
         @(posedge clock);
   endtask

   // random traffic: bursts over a small working set, some wide-range pages, rare clears
   task automatic queue_random(int count);
      int ws_base;
      int ws_size;
      int roll;
      ws_base = 0;
      ws_size = 8;
      for (int n = 0; n < count; n++) begin
         if (n % 30 == 0) begin
            ws_base = $urandom_range(0, PAGES - 1);
            ws_size = $urandom_range(4, 14);
         end
         roll = $urandom_range(0, 99);
         if (roll < 2)
            queue_clear(PAGE_ID_W'($urandom));
         else if (roll < 18)
            queue_access(PAGE_ID_W'($urandom_range(0, PAGES - 1)));
         else
            queue_access(PAGE_ID_W'((ws_base + $urandom_range(0, ws_size - 1)) % PAGES));
      end
   endtask

   // main sequence
   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: clear with a junk page, page id extremes, fill, refresh, evictions
      queue_clear(6'h3f);
      queue_access(6'd0);
      queue_access(6'd63);
      for (int p = 1; p <= 6; p++)
         queue_access(PAGE_ID_W'(p));
      queue_access(6'd0);
      queue_access(6'd7);
      queue_access(6'd42);
      queue_access(6'd0);
      queue_access(6'd6);
      queue_access(6'd21);
      queue_access(6'd42);
      queue_clear(6'd0);
      queue_access(6'd63);
      queue_access(6'd0);
      queue_access(6'd63);
      drain();

      queue_random(N_RANDOM / 2);
      drain();
      queue_random(N_RANDOM - N_RANDOM / 2);
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d beats: %0d hits, %0d evictions, %0d clears, %0d results checked",
               beats_sent, hit_count, evict_count, clear_count, beats_checked);
      $display("both channels saw random gaps and back-pressure, with full drains in between");
      if (mismatch_count == 0) begin
         $display("lru_page_replacement verification clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("lru_page_replacement verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results still awaited", awaited_results.size());
      $display("lru_page_replacement verification failed");
      $finish;
   end

endmodule

// ===== lru_page_replacement.f =====
src/lru_pr_pkg.sv
src/lru_pr_if.sv
src/lru_pr_frame_tbl.sv
src/lru_pr_page_tbl.sv
src/lru_pr_ctrl.sv
src/lru_page_replacement.sv
src/lru_pr_checker.sv
sim/lru_page_replacement_tb.sv
